>>> design/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
// No dependencies; used by every other file of the block but spq_ram.
package spq_pkg;

    localparam int CAPACITY_DEF = 32;
    localparam int TAG_BITS_DEF = 32;

    localparam int PRIO_W  = 16;
    localparam int TAG_F_W = 32;
    localparam int CNT_F_W = 6;

    localparam logic [1:0] CMD_ENQUEUE = 2'd0;
    localparam logic [1:0] CMD_DEQUEUE = 2'd1;
    localparam logic [1:0] CMD_FIND    = 2'd2;
    localparam logic [1:0] CMD_REMOVE  = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EMPTY    = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic [1:0]         command;
        logic [PRIO_W-1:0]  req_priority;
        logic [TAG_F_W-1:0] req_tag;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [TAG_F_W-1:0] out_tag;
        logic [PRIO_W-1:0]  out_priority;
        logic [CNT_F_W-1:0] entry_count;
    } rsp_t;

    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_COUNT,
        IDX_TAIL,
        IDX_ZERO,
        IDX_INC,
        IDX_DEC
    } idx_op_t;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC
    } cnt_op_t;

    typedef struct packed {
        logic       load;
        idx_op_t    idx_op;
        logic       rd_back;
        logic       wr_en;
        logic       wr_new;
        logic       wr_back;
        cnt_op_t    cnt_op;
        logic       res_load;
        logic [1:0] res_status;
        logic       res_take;
    } ctl_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic idx_zero;
        logic idx_last;
        logic prio_gt;
        logic tag_hit;
    } sts_t;

endpackage

>>> design/spq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module spq_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

>>> design/spq_ctrl.sv
// Request sequencer of the sorted priority queue.
// Depends on spq_pkg; drives spq_datapath through spq_pkg::ctl_t.
module spq_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [1:0]    command,
    input  spq_pkg::sts_t sts,
    output spq_pkg::ctl_t ctl,
    output logic          busy,
    output logic          done
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ENQ,
        S_DEQ,
        S_SCAN,
        S_SHIFT
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] op_reg, op_next;
    logic       done_reg;

    always_comb
    begin
        ctl            = '0;
        ctl.idx_op     = spq_pkg::IDX_HOLD;
        ctl.cnt_op     = spq_pkg::CNT_HOLD;
        ctl.res_status = spq_pkg::ST_OK;
        state_next     = state_reg;
        op_next        = op_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.load = 1'b1;
                    op_next  = command;
                    case (command)
                        spq_pkg::CMD_ENQUEUE:
                        begin
                            if (sts.full)
                            begin
                                ctl.res_load   = 1'b1;
                                ctl.res_status = spq_pkg::ST_FULL;
                            end
                            else
                            begin
                                ctl.idx_op  = spq_pkg::IDX_COUNT;
                                ctl.rd_back = 1'b1;
                                state_next  = S_ENQ;
                            end
                        end
                        spq_pkg::CMD_DEQUEUE:
                        begin
                            if (sts.empty)
                            begin
                                ctl.res_load   = 1'b1;
                                ctl.res_status = spq_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                ctl.idx_op = spq_pkg::IDX_TAIL;
                                state_next = S_DEQ;
                            end
                        end
                        default:
                        begin
                            if (sts.empty)
                            begin
                                ctl.res_load   = 1'b1;
                                ctl.res_status = spq_pkg::ST_NOTFOUND;
                            end
                            else
                            begin
                                ctl.idx_op = spq_pkg::IDX_ZERO;
                                state_next = S_SCAN;
                            end
                        end
                    endcase
                end
            end
            S_ENQ:
            begin
                ctl.wr_en = 1'b1;
                if (sts.idx_zero || sts.prio_gt)
                begin
                    ctl.wr_new   = 1'b1;
                    ctl.cnt_op   = spq_pkg::CNT_INC;
                    ctl.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
                else
                begin
                    ctl.idx_op  = spq_pkg::IDX_DEC;
                    ctl.rd_back = 1'b1;
                end
            end
            S_DEQ:
            begin
                ctl.cnt_op   = spq_pkg::CNT_DEC;
                ctl.res_load = 1'b1;
                ctl.res_take = 1'b1;
                state_next   = S_IDLE;
            end
            S_SCAN:
            begin
                if (sts.tag_hit)
                begin
                    if (op_reg == spq_pkg::CMD_FIND)
                    begin
                        ctl.res_load = 1'b1;
                        ctl.res_take = 1'b1;
                        state_next   = S_IDLE;
                    end
                    else if (sts.idx_last)
                    begin
                        ctl.cnt_op   = spq_pkg::CNT_DEC;
                        ctl.res_load = 1'b1;
                        state_next   = S_IDLE;
                    end
                    else
                    begin
                        ctl.idx_op = spq_pkg::IDX_INC;
                        state_next = S_SHIFT;
                    end
                end
                else if (sts.idx_last)
                begin
                    ctl.res_load   = 1'b1;
                    ctl.res_status = spq_pkg::ST_NOTFOUND;
                    state_next     = S_IDLE;
                end
                else
                begin
                    ctl.idx_op = spq_pkg::IDX_INC;
                end
            end
            S_SHIFT:
            begin
                // close the gap: move this entry down one slot
                ctl.wr_en   = 1'b1;
                ctl.wr_back = 1'b1;
                if (sts.idx_last)
                begin
                    ctl.cnt_op   = spq_pkg::CNT_DEC;
                    ctl.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
                else
                begin
                    ctl.idx_op = spq_pkg::IDX_INC;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= spq_pkg::CMD_ENQUEUE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            done_reg  <= ctl.res_load;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

    a_no_spurious_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && !start) |=> !done_reg)
        else $error("result strobe without a request");

    a_shift_only_remove: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT) |-> (op_reg == spq_pkg::CMD_REMOVE))
        else $error("shift pass outside a remove");

    a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN || state_reg == S_SHIFT || state_reg == S_DEQ)
        |-> !sts.empty)
        else $error("walk over an empty queue");

endmodule

>>> design/spq_datapath.sv
// Datapath of the sorted priority queue: entry RAM, walk index, count, result register.
// Depends on spq_pkg and spq_ram; steered by spq_ctrl through spq_pkg::ctl_t.
module spq_datapath #(
    parameter int CAPACITY = spq_pkg::CAPACITY_DEF,
    parameter int TAG_BITS = spq_pkg::TAG_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  spq_pkg::req_t req,
    input  spq_pkg::ctl_t ctl,
    output spq_pkg::sts_t sts,
    output spq_pkg::rsp_t rsp
);

    localparam int TAG_W = (TAG_BITS < spq_pkg::TAG_F_W) ? TAG_BITS : spq_pkg::TAG_F_W;
    localparam int ENT_W = spq_pkg::PRIO_W + TAG_W;
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [spq_pkg::PRIO_W-1:0] prio_reg;
    logic [TAG_W-1:0]           tag_reg;
    logic [IDX_W-1:0]           idx_reg, idx_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    spq_pkg::rsp_t              rsp_reg;

    logic [IDX_W-1:0]           rd_addr, wr_addr;
    logic [ENT_W-1:0]           rd_data, wr_data;
    logic [spq_pkg::PRIO_W-1:0] rd_prio;
    logic [TAG_W-1:0]           rd_tag;

    assign rd_prio = rd_data[ENT_W-1:TAG_W];
    assign rd_tag  = rd_data[TAG_W-1:0];

    always_comb
    begin
        case (ctl.idx_op)
            spq_pkg::IDX_COUNT: idx_next = IDX_W'(count_reg);
            spq_pkg::IDX_TAIL:  idx_next = IDX_W'(count_reg - CNT_W'(1));
            spq_pkg::IDX_ZERO:  idx_next = '0;
            spq_pkg::IDX_INC:   idx_next = idx_reg + IDX_W'(1);
            spq_pkg::IDX_DEC:   idx_next = idx_reg - IDX_W'(1);
            default:            idx_next = idx_reg;
        endcase
    end

    always_comb
    begin
        case (ctl.cnt_op)
            spq_pkg::CNT_INC: count_next = count_reg + CNT_W'(1);
            spq_pkg::CNT_DEC: count_next = count_reg - CNT_W'(1);
            default:          count_next = count_reg;
        endcase
    end

    // read ahead: the entry at the next index (or the one below it, with rd_back) arrives with the next cycle
    assign rd_addr = ctl.rd_back ? (idx_next - IDX_W'(1)) : idx_next;
    assign wr_addr = ctl.wr_back ? (idx_reg - IDX_W'(1)) : idx_reg;
    assign wr_data = ctl.wr_new ? {prio_reg, tag_reg} : rd_data;

    spq_ram #(
        .WIDTH (ENT_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ctl.wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            idx_reg   <= idx_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            prio_reg <= req.req_priority;
            tag_reg  <= req.req_tag[TAG_W-1:0];
        end
        if (ctl.res_load)
        begin
            rsp_reg.status       <= ctl.res_status;
            rsp_reg.out_tag      <= ctl.res_take ? spq_pkg::TAG_F_W'(rd_tag) : '0;
            rsp_reg.out_priority <= ctl.res_take ? rd_prio : '0;
            rsp_reg.entry_count  <= spq_pkg::CNT_F_W'(count_next);
        end
    end

    assign sts.full     = (count_reg == CNT_W'(CAPACITY));
    assign sts.empty    = (count_reg == '0);
    assign sts.idx_zero = (idx_reg == '0);
    assign sts.idx_last = (CNT_W'(idx_reg) == (count_reg - CNT_W'(1)));
    assign sts.prio_gt  = (rd_prio > prio_reg);
    assign sts.tag_hit  = (rd_tag == tag_reg);
    assign rsp          = rsp_reg;

    a_inc_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.cnt_op == spq_pkg::CNT_INC) |-> !sts.full)
        else $error("count raised past capacity");

    a_dec_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.cnt_op == spq_pkg::CNT_DEC) |-> !sts.empty)
        else $error("count lowered below zero");

    a_wr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.wr_en |-> (CNT_W'(wr_addr) < CNT_W'(CAPACITY)))
        else $error("entry write outside the store");

endmodule

>>> design/sorted_priority_queue.sv
// Top level of the sorted priority queue.
// Depends on spq_pkg, spq_ram, spq_ctrl and spq_datapath.
//
// Holds up to CAPACITY entries (priority, tag) in descending priority, equal
// priorities newest first. A request beat is taken at a rising edge with
// start high and busy low; its single result is on rsp with done high for exactly
// one cycle, and the receiver cannot stall it, so capture rsp whenever
// done is seen. Enqueue when full, dequeue when empty and find or remove on an
// empty queue answer on the edge after the request, and busy stays low.
// Otherwise the block walks the entry RAM one entry per cycle through its
// single read port (a dequeue reads only the tail entry) and keeps busy high
// until done. A new request may be issued in the cycle done is high.
// Tags are compared on their low TAG_BITS bits (at most 32). The entry RAM needs
// no clearing after reset: only entries below the count are ever used.
module sorted_priority_queue #(
    parameter int CAPACITY = spq_pkg::CAPACITY_DEF,
    parameter int TAG_BITS = spq_pkg::TAG_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  spq_pkg::req_t req,
    output logic          done,
    output spq_pkg::rsp_t rsp
);

    spq_pkg::ctl_t ctl;
    spq_pkg::sts_t sts;

    // sequencer: decides each step of the walk from the datapath status
    spq_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (req.command),
        .sts     (sts),
        .ctl     (ctl),
        .busy    (busy),
        .done    (done)
    );

    // storage, walk index, entry count and result register
    spq_datapath #(
        .CAPACITY (CAPACITY),
        .TAG_BITS (TAG_BITS)
    ) u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .ctl   (ctl),
        .sts   (sts),
        .rsp   (rsp)
    );

endmodule
